### hdl/aeba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alternating-end block allocator package
// Shared sizes, result status codes and the used-map command bundle.
// ----------------------------------------------------------------------------
package aeba_pkg;

   localparam int NUM_BLOCKS = 64;
   localparam int IDX_W      = $clog2(NUM_BLOCKS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int TOTAL_W    = 7;
   localparam int NEED_W     = 8;
   localparam int STATUS_W   = 2;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FAIL = 2'd2;

   // Commands from the sequencer to the used-block map.
   typedef struct packed {
      logic             set;
      logic             clear;
      logic             clear_all;
      logic [IDX_W-1:0] wr_idx;
   } map_cmd_type;

   // Blocks actually in use: the register value capped at the disk size.
   function automatic logic [CNT_W-1:0] eff_total(input logic [TOTAL_W-1:0] total);
      logic [CNT_W-1:0] result;
      if (total > TOTAL_W'(NUM_BLOCKS)) begin
         result = CNT_W'(NUM_BLOCKS);
      end else begin
         result = CNT_W'(total);
      end
      return result;
   endfunction

endpackage

### hdl/aeba_used_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Used-block map
// One flag per disk block with a single read port, a set/clear write port and
// a clear of the whole map.
// ----------------------------------------------------------------------------
module aeba_used_map
   import aeba_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  map_cmd_type      cmd,
   input  logic [IDX_W-1:0] rd_idx,
   output logic             rd_used
);

   logic [NUM_BLOCKS-1:0] used_ff;
   logic [NUM_BLOCKS-1:0] used_in;

   always_comb begin
      used_in = used_ff;
      if (cmd.clear_all) begin
         used_in = '0;
      end else if (cmd.set) begin
         used_in[cmd.wr_idx] = 1'b1;
      end else if (cmd.clear) begin
         used_in[cmd.wr_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   assign rd_used = used_ff[rd_idx];

endmodule

### hdl/alternating_end_block_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alternating-end block allocator
// Allocates a chain of disk blocks per request, taking blocks alternately from
// the low and the high end of the free space, and streams the chain out.
// ----------------------------------------------------------------------------
// Operation: after a request is accepted, each block is found by a pointer
//   scan that steps over used blocks and is then taken; once the ends have
//   crossed, a lowest-free scan over the first total_blocks blocks is used
//   instead, and the request fails when that scan finds nothing.
//   The used map is read through one port, once per cycle.
// Each OK result passes through a chain memory read, a load and the handshake;
//   a failure first frees the taken blocks, each with a read and a clear.
//   A finish state after the final result returns the sequencer to idle.
// Throughput: one request at a time; req_tready is high only while idle.
// Reset: synchronous, active high; the map is cleared, the pointers and the
//   alternation flag take their start values and total_blocks becomes 64.
// ----------------------------------------------------------------------------
module alternating_end_block_allocator_top
   import aeba_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // Request channel.
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // [7:0] blocks_needed
   input  logic               req_tlast,   // last_request
   // Result channel.
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,   // [5:0] block_index, [7:6] zero
   output logic [1:0]         rsp_tuser,   // [1:0] status
   output logic               rsp_tlast,   // last_result
   // Configuration: total_blocks.
   input  logic               csr_we,
   input  logic [TOTAL_W-1:0] csr_wdata
);

   // Sequencer states.
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_TURN    = 4'd1;
   localparam logic [3:0] S_FALL    = 4'd2;
   localparam logic [3:0] S_TAKE    = 4'd3;
   localparam logic [3:0] S_FREE_RD = 4'd4;
   localparam logic [3:0] S_FREE_CL = 4'd5;
   localparam logic [3:0] S_EMIT_RD = 4'd6;
   localparam logic [3:0] S_EMIT_LD = 4'd7;
   localparam logic [3:0] S_RESP    = 4'd8;
   localparam logic [3:0] S_FINISH  = 4'd9;

   logic [3:0]          state_ff, state_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   // The left pointer and the right pointer plus one; the ends have not
   // crossed while left < right plus one.
   logic [CNT_W-1:0]    left_ff, left_in;
   logic [CNT_W-1:0]    rp1_ff, rp1_in;
   logic                from_left_ff, from_left_in;
   logic [NEED_W-1:0]   remain_ff, remain_in;
   logic                last_req_ff, last_req_in;
   logic [CNT_W-1:0]    taken_ff, taken_in;     // blocks in the chain so far
   logic [CNT_W-1:0]    rd_cnt_ff, rd_cnt_in;   // chain position being read
   logic [CNT_W-1:0]    fall_ff, fall_in;       // fallback scan position
   logic [IDX_W-1:0]    pick_ff, pick_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   // Chain memory: block numbers in allocation order.
   logic [IDX_W-1:0]    chain_mem [NUM_BLOCKS];
   logic [IDX_W-1:0]    chain_rd_ff;
   logic                chain_we;
   logic                chain_re;

   map_cmd_type         map_cmd;
   logic [IDX_W-1:0]    map_rd_idx;
   logic                map_used;

   logic [CNT_W-1:0]    tb;
   logic [CNT_W-1:0]    rp1_less;
   logic                open;

   assign tb       = eff_total(total_ff);
   assign rp1_less = rp1_ff - CNT_W'(1);
   assign open     = (left_ff < rp1_ff);

   aeba_used_map u_map (
      .clock   (clock),
      .reset   (reset),
      .cmd     (map_cmd),
      .rd_idx  (map_rd_idx),
      .rd_used (map_used)
   );

   // The single map read port serves the pointer scans and the fallback scan.
   always_comb begin
      case (state_ff)
         S_TURN: begin
            map_rd_idx = from_left_ff ? left_ff[IDX_W-1:0] : rp1_less[IDX_W-1:0];
         end
         default: begin
            map_rd_idx = fall_ff[IDX_W-1:0];
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      left_in       = left_ff;
      rp1_in        = rp1_ff;
      from_left_in  = from_left_ff;
      remain_in     = remain_ff;
      last_req_in   = last_req_ff;
      taken_in      = taken_ff;
      rd_cnt_in     = rd_cnt_ff;
      fall_in       = fall_ff;
      pick_in       = pick_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      chain_we      = 1'b0;
      chain_re      = 1'b0;
      map_cmd       = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               remain_in   = req_tdata;
               last_req_in = req_tlast;
               taken_in    = '0;
               if (req_tdata == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_index_in  = '0;
                  rsp_status_in = STATUS_ZERO;
                  rsp_last_in   = 1'b1;
                  state_in      = S_RESP;
               end else begin
                  state_in = S_TURN;
               end
            end
         end

         // One scan step on the current end, or the switch to the fallback.
         S_TURN: begin
            if (!open) begin
               from_left_in = !from_left_ff;
               fall_in      = '0;
               state_in     = S_FALL;
            end else if (from_left_ff) begin
               left_in = left_ff + CNT_W'(1);
               if (!map_used) begin
                  pick_in      = left_ff[IDX_W-1:0];
                  from_left_in = 1'b0;
                  state_in     = S_TAKE;
               end
            end else begin
               rp1_in = rp1_less;
               if (!map_used) begin
                  pick_in      = rp1_less[IDX_W-1:0];
                  from_left_in = 1'b1;
                  state_in     = S_TAKE;
               end
            end
         end

         // Lowest free block of the whole disk once the ends have crossed.
         S_FALL: begin
            if (fall_ff < tb) begin
               if (!map_used) begin
                  pick_in  = fall_ff[IDX_W-1:0];
                  state_in = S_TAKE;
               end else begin
                  fall_in = fall_ff + CNT_W'(1);
               end
            end else begin
               rd_cnt_in = '0;
               state_in  = S_FREE_RD;
            end
         end

         S_TAKE: begin
            if (taken_ff == CNT_W'(NUM_BLOCKS)) begin
               rd_cnt_in = '0;
               state_in  = S_FREE_RD;
            end else begin
               map_cmd.set    = 1'b1;
               map_cmd.wr_idx = pick_ff;
               chain_we       = 1'b1;
               taken_in       = taken_ff + CNT_W'(1);
               remain_in      = remain_ff - NEED_W'(1);
               rd_cnt_in      = '0;
               state_in       = (remain_ff == NEED_W'(1)) ? S_EMIT_RD : S_TURN;
            end
         end

         // Give back every block of the failed request.
         S_FREE_RD: begin
            if (rd_cnt_ff < taken_ff) begin
               chain_re = 1'b1;
               state_in = S_FREE_CL;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = '0;
               rsp_status_in = STATUS_FAIL;
               rsp_last_in   = 1'b1;
               state_in      = S_RESP;
            end
         end

         S_FREE_CL: begin
            map_cmd.clear  = 1'b1;
            map_cmd.wr_idx = chain_rd_ff;
            rd_cnt_in      = rd_cnt_ff + CNT_W'(1);
            state_in       = S_FREE_RD;
         end

         S_EMIT_RD: begin
            chain_re = 1'b1;
            state_in = S_EMIT_LD;
         end

         S_EMIT_LD: begin
            rsp_valid_in  = 1'b1;
            rsp_index_in  = chain_rd_ff;
            rsp_status_in = STATUS_OK;
            rsp_last_in   = ((rd_cnt_ff + CNT_W'(1)) == taken_ff);
            state_in      = S_RESP;
         end

         S_RESP: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = S_FINISH;
               end else begin
                  rd_cnt_in = rd_cnt_ff + CNT_W'(1);
                  state_in  = S_EMIT_RD;
               end
            end
         end

         S_FINISH: begin
            if (last_req_ff) begin
               map_cmd.clear_all = 1'b1;
               left_in           = '0;
               rp1_in            = tb;
               from_left_in      = 1'b1;
            end
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A register write restarts the run under the new total.
      if (csr_we) begin
         total_in          = csr_wdata;
         map_cmd.clear_all = 1'b1;
         left_in           = '0;
         rp1_in            = eff_total(csr_wdata);
         from_left_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= TOTAL_W'(NUM_BLOCKS);
         left_ff      <= '0;
         rp1_ff       <= eff_total(TOTAL_W'(NUM_BLOCKS));
         from_left_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         left_ff      <= left_in;
         rp1_ff       <= rp1_in;
         from_left_ff <= from_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      remain_ff     <= remain_in;
      last_req_ff   <= last_req_in;
      taken_ff      <= taken_in;
      rd_cnt_ff     <= rd_cnt_in;
      fall_ff       <= fall_in;
      pick_ff       <= pick_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Chain memory with a registered read port.
   always_ff @(posedge clock) begin
      if (chain_we) begin
         chain_mem[taken_ff[IDX_W-1:0]] <= pick_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (chain_re) begin
         chain_rd_ff <= chain_mem[rd_cnt_ff[IDX_W-1:0]];
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_index_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
